>>> design/tepq_pkg.sv
// types and codes shared by the timed event priority queue
`default_nettype none

package tepq_pkg;

  // operation codes of a request
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_PURGE  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // status codes of a result
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FINAL,
    S_DONE
  } state_t;

  // one request
  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] event_time;
    logic [1:0]  event_kind;
    logic [15:0] process_id;
  } req_t;

  // one result
  typedef struct packed {
    logic [1:0]  status;
    logic        event_valid;
    logic [31:0] out_time;
    logic [1:0]  out_kind;
    logic [15:0] out_process;
    logic [4:0]  removed_count;
    logic [4:0]  occupancy;
  } res_t;

  // one stored event
  typedef struct packed {
    logic [31:0] ev_time;
    logic [1:0]  ev_kind;
    logic [15:0] ev_process;
  } entry_t;

endpackage

`default_nettype wire

>>> design/timed_event_priority_queue.sv
// timed event priority queue: sorted event store in one memory with a walking controller
`default_nettype none

// A request is taken when start is high and busy is low; busy then stays high until
// the single result has been shown on out_res for one cycle, marked by out_valid.
// Events are kept sorted by due tick in one memory with one read and one write port,
// and an operation walks the stored entries through that read port, one entry a
// cycle: a pop or purge walks every stored event, and an insert walks the stored
// events due later than the new one and then the first one that is not. An insert
// into an empty or a full store, a pop or purge on an empty store and an unused code
// walk nothing. Results cannot be held off.
module timed_event_priority_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output      logic            busy,
  input  wire tepq_pkg::req_t  in_req,
  output      logic            out_valid,
  output      tepq_pkg::res_t  out_res
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // event store
  tepq_pkg::entry_t slot_mem [QUEUE_DEPTH];

  // control registers
  tepq_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_left_r, rd_left_nxt;
  logic             pend_r, pend_nxt;

  // datapath registers
  tepq_pkg::req_t   req_r, req_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] pend_idx_r, pend_idx_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             ev_valid_r, ev_valid_nxt;
  tepq_pkg::entry_t ev_r, ev_nxt;
  tepq_pkg::entry_t rdata_r;

  // memory port signals
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  tepq_pkg::entry_t wr_data;

  // walk decode
  tepq_pkg::op_t    op;
  tepq_pkg::entry_t new_ent;
  logic             ins_later;
  logic             pid_match;
  logic             last_entry;
  logic             walk_end;
  logic             full;
  logic             empty;

  assign op          = tepq_pkg::op_t'(req_r.operation);
  assign new_ent     = '{ev_time: req_r.event_time, ev_kind: req_r.event_kind,
                         ev_process: req_r.process_id};
  assign ins_later   = rdata_r.ev_time > req_r.event_time;
  assign pid_match   = rdata_r.ev_process == req_r.process_id;
  assign last_entry  = CNT_W'(pend_idx_r) == (count_r - CNT_W'(1));
  assign full        = count_r == CNT_W'(QUEUE_DEPTH);
  assign empty       = count_r == '0;

  // the walk finishes on the entry that settles the request
  always_comb begin
    walk_end = 1'b0;
    if (pend_r) begin
      if (op == tepq_pkg::OP_INSERT) begin
        walk_end = !ins_later || (pend_idx_r == '0);
      end else begin
        walk_end = last_entry;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tepq_pkg::S_IDLE: begin
        if (start) begin
          unique case (tepq_pkg::op_t'(in_req.operation))
            tepq_pkg::OP_INSERT: begin
              if (full) begin
                state_nxt = tepq_pkg::S_DONE;
              end else if (empty) begin
                state_nxt = tepq_pkg::S_FINAL;
              end else begin
                state_nxt = tepq_pkg::S_WALK;
              end
            end
            tepq_pkg::OP_POP, tepq_pkg::OP_PURGE: begin
              state_nxt = empty ? tepq_pkg::S_DONE : tepq_pkg::S_WALK;
            end
            default: state_nxt = tepq_pkg::S_DONE;
          endcase
        end
      end
      tepq_pkg::S_WALK: begin
        if (walk_end) begin
          if (op == tepq_pkg::OP_INSERT && ins_later) begin
            state_nxt = tepq_pkg::S_FINAL;
          end else begin
            state_nxt = tepq_pkg::S_DONE;
          end
        end
      end
      tepq_pkg::S_FINAL: state_nxt = tepq_pkg::S_DONE;
      tepq_pkg::S_DONE:  state_nxt = tepq_pkg::S_IDLE;
      default:           state_nxt = tepq_pkg::S_IDLE;
    endcase
  end

  // walk datapath: reads run one entry ahead of the write-back, so the
  // entry being read is never the one being written and needs no forwarding
  always_comb begin
    count_nxt    = count_r;
    rd_left_nxt  = rd_left_r;
    pend_nxt     = 1'b0;
    req_nxt      = req_r;
    rd_idx_nxt   = rd_idx_r;
    pend_idx_nxt = pend_idx_r;
    wr_idx_nxt   = wr_idx_r;
    removed_nxt  = removed_r;
    status_nxt   = status_r;
    ev_valid_nxt = ev_valid_r;
    ev_nxt       = ev_r;
    rd_en        = 1'b0;
    rd_addr      = rd_idx_r;
    wr_en        = 1'b0;
    wr_addr      = wr_idx_r;
    wr_data      = rdata_r;
    unique case (state_r)
      tepq_pkg::S_IDLE: begin
        if (start) begin
          req_nxt      = in_req;
          status_nxt   = tepq_pkg::ST_DONE;
          ev_valid_nxt = 1'b0;
          ev_nxt       = '0;
          removed_nxt  = '0;
          wr_idx_nxt   = '0;
          rd_left_nxt  = count_r;
          if (tepq_pkg::op_t'(in_req.operation) == tepq_pkg::OP_INSERT) begin
            rd_idx_nxt = IDX_W'(count_r - CNT_W'(1));
            if (full) begin
              status_nxt = tepq_pkg::ST_FULL;
            end
          end else begin
            rd_idx_nxt = '0;
            if (tepq_pkg::op_t'(in_req.operation) == tepq_pkg::OP_POP && empty) begin
              status_nxt = tepq_pkg::ST_EMPTY;
            end
          end
        end
      end
      tepq_pkg::S_WALK: begin
        // issue the next read
        if (rd_left_r != '0) begin
          rd_en        = 1'b1;
          rd_left_nxt  = rd_left_r - CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_idx_r;
          if (op == tepq_pkg::OP_INSERT) begin
            rd_idx_nxt = rd_idx_r - IDX_W'(1);
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
        // handle the entry read last cycle
        if (pend_r) begin
          unique case (op)
            tepq_pkg::OP_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = pend_idx_r + IDX_W'(1);
              if (ins_later) begin
                wr_data = rdata_r;
              end else begin
                wr_data   = new_ent;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            tepq_pkg::OP_POP: begin
              if (pend_idx_r == '0) begin
                ev_valid_nxt = 1'b1;
                ev_nxt       = rdata_r;
              end else begin
                wr_en   = 1'b1;
                wr_addr = pend_idx_r - IDX_W'(1);
              end
              if (walk_end) begin
                count_nxt = count_r - CNT_W'(1);
              end
            end
            tepq_pkg::OP_PURGE: begin
              if (pid_match) begin
                removed_nxt = removed_r + CNT_W'(1);
              end else begin
                wr_en      = 1'b1;
                wr_addr    = wr_idx_r;
                wr_idx_nxt = wr_idx_r + IDX_W'(1);
              end
              if (walk_end) begin
                count_nxt = count_r - removed_nxt;
              end
            end
            default: ;
          endcase
        end
        // drop reads still in flight once the walk is over
        if (walk_end) begin
          pend_nxt    = 1'b0;
          rd_left_nxt = '0;
        end
      end
      tepq_pkg::S_FINAL: begin
        // new event goes to the front
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = new_ent;
        count_nxt = count_r + CNT_W'(1);
      end
      tepq_pkg::S_DONE: ;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy                  = state_r != tepq_pkg::S_IDLE;
    out_valid             = state_r == tepq_pkg::S_DONE;
    out_res.status        = status_r;
    out_res.event_valid   = ev_valid_r;
    out_res.out_time      = ev_r.ev_time;
    out_res.out_kind      = ev_r.ev_kind;
    out_res.out_process   = ev_r.ev_process;
    out_res.removed_count = 5'(removed_r);
    out_res.occupancy     = 5'(count_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= tepq_pkg::S_IDLE;
      count_r   <= '0;
      rd_left_r <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_left_r <= rd_left_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    rd_idx_r   <= rd_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_r       <= ev_nxt;
  end

  // event store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= slot_mem[rd_addr];
    end
  end

  // result strobe lasts a single cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // store never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("stored count beyond depth");

  // a taken request keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // a full report only comes with a full store
  a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == tepq_pkg::ST_FULL) |->
      (count_r == CNT_W'(QUEUE_DEPTH)))
    else $error("full status with spare room");

  // a returned event comes only from a successful pop
  a_event_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.event_valid) |->
      (op == tepq_pkg::OP_POP && out_res.status == tepq_pkg::ST_DONE))
    else $error("event returned outside a pop");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// self-checking testbench for the timed event priority queue
`default_nettype none

module tb_top;
  import tepq_pkg::*;

  localparam int QUEUE_DEPTH   = 16;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TAIL_CYCLES   = 40;

  // shadow of the event store and the results it implies
  class event_scoreboard;
    entry_t shadow_events[$];
    res_t   awaited_results[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    // work out the result of one accepted request and update the shadow store
    function void note_request(req_t r);
      res_t   want;
      entry_t ev;
      entry_t kept[$];
      int     pos;
      op_t    op;
      want = '0;
      op = op_t'(r.operation);
      case (op)
        OP_INSERT: begin
          if (shadow_events.size() >= QUEUE_DEPTH) begin
            want.status = ST_FULL;
          end else begin
            // equal ticks go behind the stored ones
            pos = 0;
            while (pos < shadow_events.size() && shadow_events[pos].ev_time <= r.event_time)
              pos++;
            ev.ev_time    = r.event_time;
            ev.ev_kind    = r.event_kind;
            ev.ev_process = r.process_id;
            shadow_events.insert(pos, ev);
            want.status = ST_DONE;
          end
        end
        OP_POP: begin
          if (shadow_events.size() == 0) begin
            want.status = ST_EMPTY;
          end else begin
            ev = shadow_events.pop_front();
            want.status      = ST_DONE;
            want.event_valid = 1'b1;
            want.out_time    = ev.ev_time;
            want.out_kind    = ev.ev_kind;
            want.out_process = ev.ev_process;
          end
        end
        OP_PURGE: begin
          foreach (shadow_events[i])
            if (shadow_events[i].ev_process != r.process_id) kept.push_back(shadow_events[i]);
          want.status        = ST_DONE;
          want.removed_count = 5'(shadow_events.size() - kept.size());
          shadow_events = kept;
        end
        OP_NONE: begin
          want.status = ST_DONE;
        end
        default: begin
          want.status = ST_DONE;
        end
      endcase
      want.occupancy = 5'(shadow_events.size());
      awaited_results.push_back(want);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t mismatch on %s: expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // compare one result with the oldest awaited one
    function void check_result(res_t got);
      res_t want;
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none actual %p", $time, got);
        return;
      end
      want = awaited_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("event_valid", 32'(want.event_valid), 32'(got.event_valid));
      compare_field("out_time", want.out_time, got.out_time);
      compare_field("out_kind", 32'(want.out_kind), 32'(got.out_kind));
      compare_field("out_process", 32'(want.out_process), 32'(got.out_process));
      compare_field("removed_count", 32'(want.removed_count), 32'(got.removed_count));
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t in_req = '0;
  logic out_valid;
  res_t out_res;

  event_scoreboard sb = new();

  timed_event_priority_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // result monitor, results cannot be held off
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_res);
  end

  function automatic req_t make_req(op_t op, logic [31:0] t, logic [1:0] k, logic [15:0] p);
    req_t r;
    r.operation  = op;
    r.event_time = t;
    r.event_kind = k;
    r.process_id = p;
    return r;
  endfunction

  // a small pool of owners so that purges find matches
  function automatic logic [15:0] pick_process();
    if ($urandom_range(0, 99) < 15) return 16'($urandom);
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h0002;
      3: return 16'h0007;
      4: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // mostly narrow tick ranges so that ties are common
  function automatic logic [31:0] pick_tick();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
    if (sel <= 4) return 32'($urandom_range(0, 31));
    if (sel <= 6) return 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
    return 32'($urandom);
  endfunction

  function automatic req_t random_req(int insert_pct);
    int sel;
    op_t op;
    sel = $urandom_range(0, 99);
    if (sel < insert_pct) op = OP_INSERT;
    else if (sel < insert_pct + 3) op = OP_NONE;
    else if (sel < insert_pct + 3 + (100 - insert_pct) / 4) op = OP_PURGE;
    else op = OP_POP;
    return make_req(op, pick_tick(), 2'($urandom_range(0, 3)), pick_process());
  endfunction

  // hold a request until the block takes it
  task automatic issue(req_t r);
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note_request(r);
  endtask

  // sender gap with junk on the request bus
  task automatic idle(int cycles);
    if (cycles == 0) return;
    start <= 1'b0;
    repeat (cycles) begin
      in_req <= req_t'({$urandom, $urandom});
      @(posedge clk);
    end
  endtask

  // pause the sender until every awaited result is in
  task automatic drain();
    int waited;
    waited = 0;
    if (sb.pending() == 0) return;
    start <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // stimulus
  initial begin
    int sent;
    int burst;
    int insert_pct;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty store, unused code, extremes, ties, full store, purges
    issue(make_req(OP_POP, 32'h0, 2'd0, 16'h0));
    issue(make_req(OP_PURGE, 32'h0, 2'd0, 16'h0005));
    issue(make_req(OP_NONE, 32'hFFFF_FFFF, 2'd3, 16'hFFFF));
    issue(make_req(OP_INSERT, 32'd100, 2'd0, 16'h0001));
    issue(make_req(OP_INSERT, 32'd50, 2'd1, 16'h0002));
    issue(make_req(OP_INSERT, 32'd100, 2'd2, 16'h0003));
    issue(make_req(OP_INSERT, 32'h0, 2'd3, 16'h0000));
    issue(make_req(OP_INSERT, 32'hFFFF_FFFF, 2'd0, 16'hFFFF));
    issue(make_req(OP_INSERT, 32'd100, 2'd3, 16'h0001));
    issue(make_req(OP_INSERT, 32'd75, 2'd1, 16'h0002));
    issue(make_req(OP_INSERT, 32'h8000_0000, 2'd2, 16'h0003));
    issue(make_req(OP_INSERT, 32'hFFFF_FFFF, 2'd1, 16'h0001));
    issue(make_req(OP_INSERT, 32'h0, 2'd2, 16'h0002));
    // fill up and push one more into the full store
    for (int i = 10; i <= 16; i++)
      issue(make_req(OP_INSERT, 32'(i * 7), 2'(i % 4), 16'(1 + i % 3)));
    issue(make_req(OP_PURGE, 32'h0, 2'd0, 16'h0001));
    issue(make_req(OP_PURGE, 32'h0, 2'd0, 16'h0009));
    issue(make_req(OP_POP, 32'h0, 2'd0, 16'h0));
    issue(make_req(OP_POP, 32'h0, 2'd0, 16'h0));
    issue(make_req(OP_NONE, 32'h0, 2'd0, 16'h0));
    drain();

    // random: phases that fill, hover and empty the store
    sent = 0;
    insert_pct = 55;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        if (sent % 60 == 0) begin
          case ($urandom_range(0, 2))
            0: insert_pct = 35;
            1: insert_pct = 55;
            default: insert_pct = 80;
          endcase
        end
        if (sent == RANDOM_ITEMS / 2) drain();
        issue(random_req(insert_pct));
        sent++;
      end
      if ($urandom_range(0, 3) == 0) idle(0);
      else idle($urandom_range(1, 22));
    end

    // wind down
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      $display("%0t %0d results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
